// ===== rtl/tss_pkg.sv =====
// Shared types and codes for the thread slot scheduler with semaphores.
package tss_pkg;

    localparam int OP_W     = 3;
    localparam int SLOT_F_W = 4;
    localparam int SEM_F_W  = 4;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE     = 3'd0,
        OP_TEARDOWN   = 3'd1,
        OP_SCHEDULE   = 3'd2,
        OP_SEM_INIT   = 3'd3,
        OP_SEM_WAIT   = 3'd4,
        OP_SEM_SIGNAL = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK            = 3'd0,
        STAT_FULL          = 3'd1,
        STAT_NOT_OCCUPIED  = 3'd2,
        STAT_TEAR_CURRENT  = 3'd3,
        STAT_BLOCKED       = 3'd4,
        STAT_NONE_RUNNABLE = 3'd5,
        STAT_NO_CURRENT    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        SEM_NOP  = 2'd0,
        SEM_LOAD = 2'd1,
        SEM_DEC  = 2'd2,
        SEM_INC  = 2'd3
    } sem_op_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_SCAN = 2'd2,
        S_DONE = 2'd3
    } state_t;

    typedef struct packed {
        op_t                 op;
        logic [SLOT_F_W-1:0] tgt;
        logic [SEM_F_W-1:0]  sem;
        logic [COUNT_W-1:0]  ival;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_F_W-1:0] slot;
        logic                woke;
    } res_t;

    typedef struct packed {
        sem_op_t            kind;
        logic [SEM_F_W-1:0] idx;
        logic [COUNT_W-1:0] value;
    } sem_cmd_t;

    typedef struct packed {
        logic in_range;
        logic zero;
    } sem_stat_t;

endpackage

// ===== rtl/tss_sem_file.sv =====
// Semaphore count file with one shared increment/decrement unit.
module tss_sem_file #(
    parameter int NUM_SEMAPHORES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tss_pkg::sem_cmd_t    cmd,
    output tss_pkg::sem_stat_t   stat
);

    localparam int SEM_DEPTH = (NUM_SEMAPHORES < 16) ? NUM_SEMAPHORES : 16;
    localparam int SEM_AW    = (SEM_DEPTH > 1) ? $clog2(SEM_DEPTH) : 1;

    logic [tss_pkg::COUNT_W-1:0]          cnt_reg [SEM_DEPTH];
    logic [SEM_AW+tss_pkg::SEM_F_W-1:0]   idx_ext;
    logic [SEM_AW-1:0]                    idx;
    logic                                 in_range;
    logic [tss_pkg::COUNT_W-1:0]          cur;
    logic [tss_pkg::COUNT_W-1:0]          sum;
    logic                                 wr_en;
    logic [tss_pkg::COUNT_W-1:0]          wr_data;

    // Decode the addressed entry
    assign idx_ext  = {{SEM_AW{1'b0}}, cmd.idx};
    assign idx      = idx_ext[SEM_AW-1:0];
    assign in_range = 32'(cmd.idx) < NUM_SEMAPHORES;
    assign cur      = in_range ? cnt_reg[idx] : '0;

    // Share one adder between increment and decrement
    assign sum = cur + ((cmd.kind == tss_pkg::SEM_DEC) ? {tss_pkg::COUNT_W{1'b1}}
                                                       : tss_pkg::COUNT_W'(1));

    always_comb begin
        wr_en   = 1'b0;
        wr_data = sum;
        case (cmd.kind)
            tss_pkg::SEM_LOAD: begin
                wr_en   = in_range;
                wr_data = cmd.value;
            end
            tss_pkg::SEM_DEC: wr_en = in_range && (cur != '0);
            tss_pkg::SEM_INC: wr_en = in_range && (cur != {tss_pkg::COUNT_W{1'b1}});
            default:          wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SEM_DEPTH; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (wr_en) begin
            cnt_reg[idx] <= wr_data;
        end
    end

    assign stat.in_range = in_range;
    assign stat.zero     = (cur == '0);

endmodule

// ===== rtl/tss_ctrl.sv =====
// Sequencer, slot table and round-robin slot scan of the scheduler.
module tss_ctrl #(
    parameter int MAX_THREADS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tss_pkg::req_t       in_req,
    output tss_pkg::sem_cmd_t   sem_cmd,
    input  tss_pkg::sem_stat_t  sem_stat,
    output logic                res_valid,
    output tss_pkg::res_t       res,
    input  logic                res_taken
);

    localparam int SLOT_W = $clog2(MAX_THREADS);

    tss_pkg::state_t            state_reg, state_next;
    tss_pkg::req_t              req_reg, req_next;
    tss_pkg::res_t              res_reg, res_next;
    logic [MAX_THREADS-1:0]     occ_reg, occ_next;
    logic [MAX_THREADS-1:0]     asleep_reg, asleep_next;
    logic                       cur_valid_reg, cur_valid_next;
    logic [SLOT_W-1:0]          cur_slot_reg, cur_slot_next;
    logic [SLOT_W-1:0]          idx_reg, idx_next;
    logic [SLOT_W-1:0]          cnt_reg, cnt_next;
    logic                       chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0]          chk_idx_reg, chk_idx_next;
    logic                       chk_last_reg, chk_last_next;

    // Wait-target store: read once per scan step, written by a blocked wait
    logic [tss_pkg::SEM_F_W-1:0] waits_mem [MAX_THREADS];
    logic [tss_pkg::SEM_F_W-1:0] waits_rd_reg;
    logic                        wr_en;
    logic [SLOT_W-1:0]           rd_addr;

    logic [SLOT_W+tss_pkg::SLOT_F_W-1:0] tgt_ext;
    logic [SLOT_W-1:0]                   tgt_idx;
    logic                                tgt_in_range;
    logic                                hit;

    function automatic logic [tss_pkg::SLOT_F_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+tss_pkg::SLOT_F_W-1:0] e;
        e = {{tss_pkg::SLOT_F_W{1'b0}}, s};
        return e[tss_pkg::SLOT_F_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(MAX_THREADS - 1)) ? '0 : s + 1'b1;
    endfunction

    assign tgt_ext      = {{SLOT_W{1'b0}}, req_reg.tgt};
    assign tgt_idx      = tgt_ext[SLOT_W-1:0];
    assign tgt_in_range = 32'(req_reg.tgt) < MAX_THREADS;
    assign rd_addr      = idx_reg;

    // Test the slot whose wait target just came out of the store
    always_comb begin
        case (req_reg.op)
            tss_pkg::OP_CREATE:     hit = !occ_reg[chk_idx_reg];
            tss_pkg::OP_SCHEDULE:   hit = occ_reg[chk_idx_reg] && !asleep_reg[chk_idx_reg];
            tss_pkg::OP_SEM_SIGNAL: hit = occ_reg[chk_idx_reg] && asleep_reg[chk_idx_reg]
                                          && (waits_rd_reg == req_reg.sem);
            default:                hit = 1'b0;
        endcase
    end

    // Next state and datapath control
    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        occ_next       = occ_reg;
        asleep_next    = asleep_reg;
        cur_valid_next = cur_valid_reg;
        cur_slot_next  = cur_slot_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        chk_last_next  = chk_last_reg;
        wr_en          = 1'b0;
        sem_cmd.kind   = tss_pkg::SEM_NOP;
        sem_cmd.idx    = req_reg.sem;
        sem_cmd.value  = req_reg.ival;

        unique case (state_reg)
            tss_pkg::S_IDLE: begin
                if (in_valid) begin
                    req_next   = in_req;
                    state_next = tss_pkg::S_EXEC;
                end
            end
            tss_pkg::S_EXEC: begin
                res_next     = '{status: tss_pkg::STAT_OK, slot: '0, woke: 1'b0};
                state_next   = tss_pkg::S_DONE;
                idx_next     = '0;
                cnt_next     = '0;
                chk_vld_next = 1'b0;
                case (req_reg.op)
                    tss_pkg::OP_CREATE: state_next = tss_pkg::S_SCAN;
                    tss_pkg::OP_TEARDOWN: begin
                        if (!tgt_in_range || !occ_reg[tgt_idx]) begin
                            res_next.status = tss_pkg::STAT_NOT_OCCUPIED;
                        end else if (cur_valid_reg && (cur_slot_reg == tgt_idx)) begin
                            res_next.status = tss_pkg::STAT_TEAR_CURRENT;
                        end else begin
                            occ_next[tgt_idx]    = 1'b0;
                            asleep_next[tgt_idx] = 1'b0;
                        end
                    end
                    tss_pkg::OP_SCHEDULE: begin
                        idx_next   = cur_valid_reg ? wrap_inc(cur_slot_reg) : '0;
                        state_next = tss_pkg::S_SCAN;
                    end
                    tss_pkg::OP_SEM_INIT: sem_cmd.kind = tss_pkg::SEM_LOAD;
                    tss_pkg::OP_SEM_WAIT: begin
                        if (sem_stat.in_range) begin
                            if (!cur_valid_reg) begin
                                res_next.status = tss_pkg::STAT_NO_CURRENT;
                            end else begin
                                res_next.slot = slot_out(cur_slot_reg);
                                if (!sem_stat.zero) begin
                                    sem_cmd.kind = tss_pkg::SEM_DEC;
                                end else begin
                                    asleep_next[cur_slot_reg] = 1'b1;
                                    wr_en                     = 1'b1;
                                    res_next.status           = tss_pkg::STAT_BLOCKED;
                                end
                            end
                        end
                    end
                    tss_pkg::OP_SEM_SIGNAL: begin
                        if (sem_stat.in_range) begin
                            sem_cmd.kind = tss_pkg::SEM_INC;
                            state_next   = tss_pkg::S_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            tss_pkg::S_SCAN: begin
                if (chk_vld_reg && hit) begin
                    state_next    = tss_pkg::S_DONE;
                    res_next.slot = slot_out(chk_idx_reg);
                    case (req_reg.op)
                        tss_pkg::OP_CREATE: begin
                            occ_next[chk_idx_reg]    = 1'b1;
                            asleep_next[chk_idx_reg] = 1'b0;
                        end
                        tss_pkg::OP_SCHEDULE: begin
                            cur_slot_next  = chk_idx_reg;
                            cur_valid_next = 1'b1;
                        end
                        default: begin
                            asleep_next[chk_idx_reg] = 1'b0;
                            res_next.woke            = 1'b1;
                        end
                    endcase
                end else if (chk_vld_reg && chk_last_reg) begin
                    // Scan exhausted: report the miss, leave state alone
                    state_next = tss_pkg::S_DONE;
                    case (req_reg.op)
                        tss_pkg::OP_CREATE:   res_next.status = tss_pkg::STAT_FULL;
                        tss_pkg::OP_SCHEDULE: res_next.status = tss_pkg::STAT_NONE_RUNNABLE;
                        default:              res_next.status = tss_pkg::STAT_OK;
                    endcase
                end else begin
                    // Advance: issue the next slot to the store
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = idx_reg;
                    chk_last_next = (cnt_reg == SLOT_W'(MAX_THREADS - 1));
                    idx_next      = wrap_inc(idx_reg);
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            tss_pkg::S_DONE: begin
                if (res_taken) begin
                    state_next = tss_pkg::S_IDLE;
                end
            end
            default: state_next = tss_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tss_pkg::S_IDLE;
            occ_reg       <= '0;
            asleep_reg    <= '0;
            cur_valid_reg <= 1'b0;
            cur_slot_reg  <= '0;
            chk_vld_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            asleep_reg    <= asleep_next;
            cur_valid_reg <= cur_valid_next;
            cur_slot_reg  <= cur_slot_next;
            chk_vld_reg   <= chk_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        chk_idx_reg  <= chk_idx_next;
        chk_last_reg <= chk_last_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            waits_mem[cur_slot_reg] <= req_reg.sem;
        end
        waits_rd_reg <= waits_mem[rd_addr];
    end

    assign in_ready  = (state_reg == tss_pkg::S_IDLE);
    assign res_valid = (state_reg == tss_pkg::S_DONE);
    assign res       = res_reg;

    // A current slot is always occupied
    a_cur_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> occ_reg[cur_slot_reg])
        else $error("current slot is not occupied");

    // A sleeping slot is always occupied
    a_asleep_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        (asleep_reg & ~occ_reg) == '0)
        else $error("free slot marked asleep");

    // The scan ends once the last slot has been checked
    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tss_pkg::S_SCAN) && chk_vld_reg && chk_last_reg
        |=> state_reg == tss_pkg::S_DONE)
        else $error("scan ran past the last slot");

    // Checked slot index stays inside the table
    a_chk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tss_pkg::S_SCAN) && chk_vld_reg |-> 32'(chk_idx_reg) < MAX_THREADS)
        else $error("scan index out of range");

endmodule

// ===== rtl/thread_slot_scheduler_with_semaphores_top.sv =====
// Thread slot scheduler with counting semaphores: top level with result register.
//
// Usage: one command word enters on the s_ channel (s_valid/s_ready) and one
// result word leaves on the m_ channel (m_valid/m_ready) for every command.
// Commands are create, teardown, schedule, semaphore init, wait and signal.
// The block works on one word at a time; s_ready is high only while idle.
// Teardown, init, wait and unused codes give their result straight from the
// execute step. Create, schedule and signal scan the slot table one slot per
// cycle through the wait-target store, whose read is registered; the scan
// stops at the first hit or after the last slot. The next word is accepted
// the cycle after the result is handed to the output register. The output
// register lets the next word be accepted while a result still waits; if
// m_ready stays low, the following result holds inside the block until the
// register frees up.
// Reset (aresetn low, synchronous) frees all slots, clears the current slot
// and sets every semaphore count to zero; no clearing pass is needed.
module thread_slot_scheduler_with_semaphores_top #(
    parameter int MAX_THREADS    = 16,
    parameter int NUM_SEMAPHORES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [3:0]  s_target_slot,
    input  logic [3:0]  s_sem_id,
    input  logic [15:0] s_init_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_slot_index,
    output logic        m_woke_thread
);

    tss_pkg::req_t      in_req;
    tss_pkg::sem_cmd_t  sem_cmd;
    tss_pkg::sem_stat_t sem_stat;
    tss_pkg::res_t      res;
    tss_pkg::res_t      m_res_reg;
    logic               m_valid_reg, m_valid_next;
    logic               res_valid;
    logic               res_taken;

    assign in_req.op   = tss_pkg::op_t'(s_operation);
    assign in_req.tgt  = s_target_slot;
    assign in_req.sem  = s_sem_id;
    assign in_req.ival = s_init_value;

    tss_ctrl #(
        .MAX_THREADS (MAX_THREADS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_req    (in_req),
        .sem_cmd   (sem_cmd),
        .sem_stat  (sem_stat),
        .res_valid (res_valid),
        .res       (res),
        .res_taken (res_taken)
    );

    tss_sem_file #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES)
    ) u_sem_file (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (sem_cmd),
        .stat    (sem_stat)
    );

    // Load the output register whenever it is empty or being drained
    assign res_taken = res_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_taken) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_taken) begin
            m_res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_res_reg.status;
    assign m_slot_index  = m_res_reg.slot;
    assign m_woke_thread = m_res_reg.woke;

endmodule
